### hw/rtl/wbps_pkg.sv
`default_nettype none
package wbps_pkg;

  localparam int CFG_BYTES = 16;
  localparam int LEN_W = 5;

  typedef logic [7:0] byte_t;
  typedef logic [CFG_BYTES-1:0][7:0] pattern_t;
  typedef logic [CFG_BYTES-1:0] wild_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [1:0] cfg_index_t;
  typedef logic [63:0] cfg_data_t;

  localparam cfg_index_t REG_PATTERN_LOW  = 2'd0;
  localparam cfg_index_t REG_PATTERN_HIGH = 2'd1;
  localparam cfg_index_t REG_WILD_MASK    = 2'd2;
  localparam cfg_index_t REG_PATTERN_LEN  = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] byte_addr;
    logic        region_start;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] match_addr;
  } out_t;

  function automatic logic pos_match(byte_t b, pattern_t pat, wild_t wild, len_t len,
                                     len_t age);
    logic       in_use;
    logic [3:0] pos;
    in_use = len > age;
    pos    = 4'(len - age - 5'd1);
    return !in_use || wild[pos] || (b == pat[pos]);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/wildcard_byte_pattern_scanner_unit.sv
// A result is registered and presented in the cycle after its input transaction is accepted.
// Throughput: one byte per cycle while in_ready is high; the window is a row of byte cells that shifts on
// every accepted transaction, and all positions are compared in that same cycle.
// A single output register holds the result; input stalls only while it is full and out_ready is low.
// Reset (rst, synchronous): empties the window and the output register and sets the
// pattern to zero, the wild mask to zero and the pattern length to one.
`default_nettype none
module wildcard_byte_pattern_scanner_unit import wbps_pkg::*; #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire cfg_index_t cfg_index,
  input  wire cfg_data_t  cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_item
);

  localparam int LEN_LIMIT = (MAX_PATTERN < CFG_BYTES) ? MAX_PATTERN : CFG_BYTES;
  localparam int NCELL = (LEN_LIMIT > 1) ? LEN_LIMIT - 1 : 1;

  pattern_t pattern;
  wild_t    wild;
  len_t     pattern_len;
  len_t     len_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern     <= '0;
      wild        <= '0;
      pattern_len <= len_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern[7:0]  <= cfg_wdata;
        REG_PATTERN_HIGH: pattern[15:8] <= cfg_wdata;
        REG_WILD_MASK:    wild          <= cfg_wdata[15:0];
        REG_PATTERN_LEN:  pattern_len   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (pattern_len > len_t'(LEN_LIMIT)) ? len_t'(LEN_LIMIT) : pattern_len;

  logic accept;
  assign accept = in_valid && in_ready;

  byte_t             cell_byte [NCELL];
  logic [NCELL-1:0]  cell_valid;
  logic [NCELL-1:0]  cell_ok;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    byte_t b_in;
    logic  v_in;
    logic  clr;
    if (k == 0) begin : g_head
      assign b_in = in_item.data_byte;
      assign v_in = 1'b1;
      assign clr  = 1'b0;
    end else begin : g_body
      assign b_in = cell_byte[k-1];
      assign v_in = cell_valid[k-1];
      assign clr  = in_item.region_start;
    end
    wbps_cell #(.AGE(k + 1)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (accept),
      .clear     (clr),
      .byte_in   (b_in),
      .valid_in  (v_in),
      .pattern   (pattern),
      .wild      (wild),
      .len       (len_eff),
      .byte_out  (cell_byte[k]),
      .valid_out (cell_valid[k]),
      .ok        (cell_ok[k])
    );
  end

  logic head_ok;
  logic hit;
  out_t result;

  // a region start leaves only the current byte in the window
  assign head_ok = pos_match(in_item.data_byte, pattern, wild, len_eff, len_t'(0));
  assign hit     = (len_eff != len_t'(0)) && head_ok && (&cell_ok) &&
                   (!in_item.region_start || (len_eff == len_t'(1)));

  always_comb begin
    result.hit        = hit;
    result.match_addr = hit ? (in_item.byte_addr - {27'd0, len_eff} + 32'd1) : 32'd0;
  end

  wbps_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_miss_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.hit |-> out_item.match_addr == 32'd0)
    else $error("miss carries nonzero address");

  a_valid_ordered: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("window valid bits out of order");

  a_region_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.region_start |=> $countones(cell_valid) == 1 && cell_valid[0])
    else $error("region start did not clear the window");

endmodule
`default_nettype wire

### hw/rtl/wbps_cell.sv
`default_nettype none
module wbps_cell import wbps_pkg::*; #(
  parameter int AGE = 1
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     shift,
  input  wire logic     clear,
  input  wire byte_t    byte_in,
  input  wire logic     valid_in,
  input  wire pattern_t pattern,
  input  wire wild_t    wild,
  input  wire len_t     len,
  output byte_t         byte_out,
  output logic          valid_out,
  output logic          ok
);

  byte_t held_byte;
  logic  held_valid;

  always_ff @(posedge clk) begin
    if (shift) begin
      held_byte <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (shift) begin
      held_valid <= valid_in && !clear;
    end
  end

  assign byte_out  = held_byte;
  assign valid_out = held_valid;
  assign ok        = (len <= len_t'(AGE)) ||
                     (held_valid && pos_match(held_byte, pattern, wild, len, len_t'(AGE)));

endmodule
`default_nettype wire

### hw/rtl/wbps_out_reg.sv
`default_nettype none
module wbps_out_reg import wbps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire out_t push_item,
  output logic      can_push,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_item
);

  logic full;
  out_t item;

  assign can_push  = !full || out_ready;
  assign out_valid = full;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item <= push_item;
    end
  end

endmodule
`default_nettype wire
